FILE: rtl/core/sgu_pkg.sv
// Shared types, constants and register codes for the Scharr gradient unit.
// No dependencies; the window cell, kernel and top-level files refer to this package.
`default_nettype none

package sgu_pkg;

    // Line buffer geometry.
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

    // Field widths.
    localparam int PIX_W    = 8;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // One 3-pixel column of the window.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    // Control of one window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/sgu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the two line buffers.
`default_nettype none

module sgu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/sgu_col_cell.sv
// One window cell: holds a 3-pixel column and passes it to its neighbor.
// Depends on sgu_pkg for the column and control types.
`default_nettype none

module sgu_col_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sgu_pkg::t_cell_ctrl i_ctrl,
    input  wire sgu_pkg::t_column    i_col,
    output sgu_pkg::t_column         o_col
);

    sgu_pkg::t_column r_col;
    sgu_pkg::t_column n_col;

    // Clear wins over shift so a row end starts the next row empty.
    always_comb begin
        n_col = r_col;
        if (i_ctrl.clear) begin
            n_col = '0;
        end else if (i_ctrl.shift) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

FILE: rtl/core/sgu_kernel.sv
// Scharr kernel: horizontal and vertical sums, clamp, halve and add.
// Depends on sgu_pkg for the column type.
`default_nettype none

module sgu_kernel (
    input  wire sgu_pkg::t_column  i_col_old,
    input  wire sgu_pkg::t_column  i_col_mid,
    input  wire sgu_pkg::t_column  i_col_new,
    output logic [sgu_pkg::PIX_W-1:0] o_magnitude
);

    localparam int SUM_W = 14;

    logic signed [SUM_W-1:0] w_gx;
    logic signed [SUM_W-1:0] w_gy;
    logic [6:0]              w_half_x;
    logic [6:0]              w_half_y;

    // Difference of two pixels as a signed value.
    function automatic logic signed [SUM_W-1:0] diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [SUM_W-1:0] sa;
        logic signed [SUM_W-1:0] sb;
        sa = $signed({6'b0, a});
        sb = $signed({6'b0, b});
        return sa - sb;
    endfunction

    // Constant multiplies as shift-and-add.
    function automatic logic signed [SUM_W-1:0] times3(input logic signed [SUM_W-1:0] d);
        return (d <<< 1) + d;
    endfunction

    function automatic logic signed [SUM_W-1:0] times10(input logic signed [SUM_W-1:0] d);
        return (d <<< 3) + (d <<< 1);
    endfunction

    // Clamp to 0..255, then halve.
    function automatic logic [6:0] clamp_half(input logic signed [SUM_W-1:0] g);
        logic [6:0] h;
        if (g[SUM_W-1]) begin
            h = 7'd0;
        end else if (g > 14'sd255) begin
            h = 7'd127;
        end else begin
            h = g[7:1];
        end
        return h;
    endfunction

    // Gradient sums over the window.
    assign w_gx = times3(diff(i_col_new.top, i_col_old.top))
                + times10(diff(i_col_new.mid, i_col_old.mid))
                + times3(diff(i_col_new.bot, i_col_old.bot));
    assign w_gy = times3(diff(i_col_old.bot, i_col_old.top))
                + times10(diff(i_col_mid.bot, i_col_mid.top))
                + times3(diff(i_col_new.bot, i_col_new.top));

    assign w_half_x    = clamp_half(w_gx);
    assign w_half_y    = clamp_half(w_gy);
    assign o_magnitude = {1'b0, w_half_x} + {1'b0, w_half_y};

endmodule

`default_nettype wire

FILE: rtl/core/scharr_gradient_3x3_unit.sv
// Streaming 3x3 Scharr gradient unit: top level with counters, line buffers and window.
// Depends on sgu_pkg, sgu_ram, sgu_col_cell and sgu_kernel.
//
// The unit takes one 8-bit pixel word per clock in raster order, unless the result
// channel stalls, and returns one magnitude word for each interior pixel in the cycle
// after that pixel is taken; the sustained rate is one pixel per clock. That figure is
// set by the two line buffer RAMs, whose registered read is issued ahead at the column
// of the next pixel, and by the two-cell window chain that shifts once per pixel.
// Border rows and columns give no result word, and frame_last marks the word of the
// final interior pixel. A write to the width or height register restarts the frame
// at row 0, column 0. The line buffers need no clearing pass after reset: every value
// the kernel uses is written earlier in the same frame.
`default_nettype none

module scharr_gradient_3x3_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration port.
    input  wire logic                          i_cfg_we,
    input  wire logic [sgu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sgu_pkg::CFG_W-1:0]     i_cfg_data,
    // Pixel input channel.
    input  wire logic                          i_pixel_valid,
    output logic                               o_pixel_stall,
    input  wire logic [sgu_pkg::PIX_W-1:0]     i_pixel,
    // Result output channel.
    output logic                               o_result_valid,
    input  wire logic                          i_result_stall,
    output logic [sgu_pkg::PIX_W-1:0]          o_magnitude,
    output logic                               o_frame_last
);

    localparam int COL_W = sgu_pkg::COL_W;
    localparam int ROW_W = sgu_pkg::ROW_W;

    logic [sgu_pkg::WIDTH_W-1:0]  r_image_width;
    logic [sgu_pkg::HEIGHT_W-1:0] r_image_height;
    logic [COL_W-1:0]             r_col;
    logic [COL_W-1:0]             n_col;
    logic [ROW_W-1:0]             r_row;
    logic [ROW_W-1:0]             n_row;
    logic                         r_out_valid;
    logic [sgu_pkg::PIX_W-1:0]    r_magnitude;
    logic                         r_frame_last;

    logic [COL_W-1:0]          w_last_col;
    logic [ROW_W-1:0]          w_last_row;
    logic                      w_accept;
    logic                      w_cfg_hit;
    logic                      w_row_end;
    logic                      w_interior;
    logic [sgu_pkg::PIX_W-1:0] w_above_two;
    logic [sgu_pkg::PIX_W-1:0] w_above_one;
    logic [sgu_pkg::PIX_W-1:0] w_magnitude;
    sgu_pkg::t_cell_ctrl       w_cell_ctrl;
    sgu_pkg::t_column          w_col_new;
    sgu_pkg::t_column          w_col_mid;
    sgu_pkg::t_column          w_col_old;

    // Last column and row index after clamping the programmed frame size.
    always_comb begin
        if (32'(r_image_width) < 32'd3) begin
            w_last_col = COL_W'(2);
        end else if (32'(r_image_width) > 32'(sgu_pkg::MAX_WIDTH)) begin
            w_last_col = COL_W'(sgu_pkg::MAX_WIDTH - 1);
        end else begin
            w_last_col = COL_W'(32'(r_image_width) - 32'd1);
        end
        if (32'(r_image_height) < 32'd3) begin
            w_last_row = ROW_W'(2);
        end else if (32'(r_image_height) > 32'(sgu_pkg::HEIGHT_LIMIT)) begin
            w_last_row = ROW_W'(sgu_pkg::HEIGHT_LIMIT - 1);
        end else begin
            w_last_row = ROW_W'(32'(r_image_height) - 32'd1);
        end
    end

    // Handshake: a new word is taken unless a finished result is held back.
    assign o_pixel_stall = r_out_valid && i_result_stall;
    assign w_accept      = i_pixel_valid && !o_pixel_stall;
    assign w_cfg_hit     = i_cfg_we && ((i_cfg_index == sgu_pkg::REG_IMAGE_WIDTH)
                                     || (i_cfg_index == sgu_pkg::REG_IMAGE_HEIGHT));
    assign w_row_end     = (r_col == w_last_col);
    assign w_interior    = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sgu_pkg::WIDTH_RESET;
            r_image_height <= sgu_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgu_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[sgu_pkg::WIDTH_W-1:0];
                end
                sgu_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[sgu_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position; the next column also addresses the line buffer read.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (!i_rst_n || w_cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = (r_row == w_last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line buffers: the row two above and the row one above.
    sgu_ram #(
        .WIDTH (sgu_pkg::PIX_W),
        .DEPTH (sgu_pkg::MAX_WIDTH)
    ) u_line_two (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_col),
        .i_wdata (w_above_one),
        .i_raddr (n_col),
        .o_rdata (w_above_two)
    );

    sgu_ram #(
        .WIDTH (sgu_pkg::PIX_W),
        .DEPTH (sgu_pkg::MAX_WIDTH)
    ) u_line_one (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_raddr (n_col),
        .o_rdata (w_above_one)
    );

    // Window chain: new column feeds the middle cell, which feeds the oldest.
    assign w_col_new.top     = w_above_two;
    assign w_col_new.mid     = w_above_one;
    assign w_col_new.bot     = i_pixel;
    assign w_cell_ctrl.shift = w_accept;
    assign w_cell_ctrl.clear = w_cfg_hit || (w_accept && w_row_end);

    sgu_col_cell u_cell_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_cell_ctrl),
        .i_col   (w_col_new),
        .o_col   (w_col_mid)
    );

    sgu_col_cell u_cell_old (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_cell_ctrl),
        .i_col   (w_col_mid),
        .o_col   (w_col_old)
    );

    sgu_kernel u_kernel (
        .i_col_old   (w_col_old),
        .i_col_mid   (w_col_mid),
        .i_col_new   (w_col_new),
        .o_magnitude (w_magnitude)
    );

    // Output register: holds a result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_interior) begin
            r_out_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_interior) begin
            r_magnitude  <= w_magnitude;
            r_frame_last <= w_row_end && (r_row == w_last_row);
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_magnitude    = r_magnitude;
    assign o_frame_last   = r_frame_last;

    // An interior pixel always leaves a result word behind.
    a_interior_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_interior) |=> o_result_valid)
        else $error("interior pixel produced no result word");

    // The column counter never runs past the programmed row length.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_last_col)
        else $error("column counter beyond last column");

    // After the final pixel of a frame the raster position is back at the origin.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_row_end && (r_row == w_last_row)) |=> (r_row == '0 && r_col == '0))
        else $error("frame did not wrap to row 0, column 0");

    // A write to the width or height register restarts the window empty.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (w_col_mid == '0 && w_col_old == '0 && r_col == '0))
        else $error("register write did not restart the frame");

endmodule

`default_nettype wire
